/* sv/oeal_pkg.sv */
package oeal_pkg;

  // Number format: signed Q16.16 samples, unsigned Q16.16 rates and times
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 35;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider: partial remainder width, quotient width, step counter width
  localparam int DIV_R_W = 49;
  localparam int DIV_Q_W = 32;
  localparam int DIV_C_W = 6;

  localparam logic [DATA_W-1:0]  ONE_Q      = 32'h0001_0000;
  localparam logic [DATA_W-1:0]  UMAX       = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0]  SMAX       = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]  SMIN       = 32'h8000_0000;
  // 2*pi in Q32
  localparam logic [MUL_B_W-1:0] TWO_PI_Q32 = 35'h6_487E_D511;
  // ceiling on the scaled cutoff w
  localparam logic [DIV_R_W-1:0] W_LIMIT    = 49'h1_0000_0000_0000;

  // Quotient bits per division kind
  localparam logic [DIV_C_W-1:0] SLOPE_STEPS = 6'd32;
  localparam logic [DIV_C_W-1:0] ALPHA_STEPS = 6'd16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_CUTOFF  = 2'd0,
    REG_SPEED_GAIN   = 2'd1,
    REG_SLOPE_CUTOFF = 2'd2
  } reg_idx_t;

  // Divider request: remainder preload, divisor, dividend bits fed MSB first
  typedef struct packed {
    logic               start;
    logic [DIV_C_W-1:0] steps;
    logic [DIV_R_W-1:0] rem_init;
    logic [DIV_R_W-1:0] divisor;
    logic [DIV_Q_W-1:0] bits;
  } div_cmd_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

/* sv/oeal_if.sv */
// Input sample channel
interface oeal_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [oeal_pkg::DATA_W-1:0]  sample;
  logic        [oeal_pkg::DATA_W-1:0]  time_step;

  modport source (output valid, sample, time_step, input ready);
  modport sink   (input valid, sample, time_step, output ready);
endinterface

// Filtered result channel
interface oeal_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [oeal_pkg::DATA_W-1:0]  filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

// Register write channel
interface oeal_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         index;
  logic [oeal_pkg::DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/oeal_mul.sv */
// Shared unsigned multiplier, product registered
module oeal_mul (
  input  logic                           clk,
  input  logic [oeal_pkg::MUL_A_W-1:0]   a,
  input  logic [oeal_pkg::MUL_B_W-1:0]   b,
  output logic [oeal_pkg::MUL_P_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= {{oeal_pkg::MUL_B_W{1'b0}}, a} * {{oeal_pkg::MUL_A_W{1'b0}}, b};
  end

endmodule

/* sv/oeal_div.sv */
// Restoring divider, one quotient bit per cycle.
// The preloaded remainder must be below the divisor.
module oeal_div (
  input  logic                clk,
  input  logic                rst,
  input  oeal_pkg::div_cmd_t  cmd,
  output oeal_pkg::div_rsp_t  rsp
);

  logic                             busy;
  logic                             done;
  logic [oeal_pkg::DIV_C_W-1:0]     cnt;
  logic [oeal_pkg::DIV_R_W-1:0]     rem;
  logic [oeal_pkg::DIV_R_W-1:0]     dvs;
  logic [oeal_pkg::DIV_Q_W-1:0]     shin;
  logic [oeal_pkg::DIV_Q_W-1:0]     quot;
  logic [oeal_pkg::DIV_R_W:0]       trial;
  logic                             fits;
  logic [oeal_pkg::DIV_R_W-1:0]     rem_next;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, shin[oeal_pkg::DIV_Q_W-1]};
    fits  = trial >= {1'b0, dvs};
    if (fits) begin
      rem_next = oeal_pkg::DIV_R_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[oeal_pkg::DIV_R_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - oeal_pkg::DIV_C_W'(1);
        if (cnt == oeal_pkg::DIV_C_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= cmd.rem_init;
      dvs  <= cmd.divisor;
      shin <= cmd.bits;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      shin <= {shin[oeal_pkg::DIV_Q_W-2:0], 1'b0};
      quot <= {quot[oeal_pkg::DIV_Q_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* sv/one_euro_adaptive_lowpass_core.sv */
// Channel    Role    Payload                                  Handshake
// data_in    sink    sample (s Q16.16), time_step (u Q16.16)  valid/ready
// data_out   source  filtered (s Q16.16)                      valid/ready
// cfg        sink    index (2b), data (32b)                   valid/ready, always ready
//
// A sample runs the slope division, the slope lowpass, the cutoff update, the
// estimate lowpass and the result; each lowpass runs an alpha division, and the
// divider gives one quotient bit per cycle. A zero cutoff skips its alpha division,
// an out-of-range slope skips the slope division, a first sample goes to the result.
// Synchronous reset clears the state; no input is taken while a sample is in
// work, and a result waiting on data_out stalls only the next result.
module one_euro_adaptive_lowpass_core (
  input  logic               clk,
  input  logic               rst,
  oeal_in_if.sink            data_in,
  oeal_out_if.source         data_out,
  oeal_cfg_if.sink           cfg
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SDIV  = 14'b00000000000010,
    ST_SWAIT = 14'b00000000000100,
    ST_FDMUL = 14'b00000000001000,
    ST_WLMUL = 14'b00000000010000,
    ST_WHMUL = 14'b00000000100000,
    ST_WSUM  = 14'b00000001000000,
    ST_ADIV  = 14'b00000010000000,
    ST_AWAIT = 14'b00000100000000,
    ST_SMUL  = 14'b00001000000000,
    ST_SADD  = 14'b00010000000000,
    ST_CMUL  = 14'b00100000000000,
    ST_CADD  = 14'b01000000000000,
    ST_OUT   = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration
  logic [31:0] base_cutoff;
  logic [31:0] speed_gain;
  logic [31:0] slope_cutoff;

  // Filter state
  logic [31:0] estimate;
  logic [31:0] slope_est;
  logic        started;

  // Per-sample work registers
  logic [31:0] x_in;
  logic [31:0] dt;
  logic [31:0] target;
  logic        s_neg;
  logic        d_neg;
  logic        phase;       // 0: slope lowpass, 1: estimate lowpass
  logic [31:0] freq;
  logic [15:0] fd_hi;
  logic [34:0] w_acc;
  logic [48:0] w;
  logic [16:0] alpha;
  logic [31:0] res;

  // Output register
  logic        out_valid;
  logic [31:0] out_data;

  // Shared units
  logic [oeal_pkg::MUL_A_W-1:0] mul_a;
  logic [oeal_pkg::MUL_B_W-1:0] mul_b;
  logic [oeal_pkg::MUL_P_W-1:0] prod;
  oeal_pkg::div_cmd_t           dcmd;
  oeal_pkg::div_rsp_t           drsp;

  oeal_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  oeal_div u_div (.clk(clk), .rst(rst), .cmd(dcmd), .rsp(drsp));

  // Combinational helpers
  logic        accept;
  logic        out_free;
  logic [32:0] sdiff;
  logic [31:0] smag;
  logic [31:0] prev;
  logic [31:0] tgt;
  logic [32:0] pdiff;
  logic [31:0] pmag;
  logic [31:0] delta;
  logic [33:0] psum;
  logic [31:0] smoothed;
  logic [31:0] q_lim;
  logic [31:0] q_sat;
  logic [31:0] se_mag;
  logic [31:0] extra;
  logic [32:0] cut_sum;
  logic [52:0] w_sum;

  assign accept   = data_in.valid && data_in.ready;
  assign out_free = !out_valid || data_out.ready;

  always_comb begin
    // Raw slope numerator: sample minus estimate
    sdiff = {x_in[31], x_in} - {estimate[31], estimate};
    smag  = sdiff[32] ? 32'(-sdiff) : sdiff[31:0];

    // Lowpass operands for the current phase
    prev  = phase ? estimate : slope_est;
    tgt   = phase ? x_in : target;
    pdiff = {tgt[31], tgt} - {prev[31], prev};
    pmag  = pdiff[32] ? 32'(-pdiff) : pdiff[31:0];

    // Lowpass update with signed saturation
    delta = prod[47:16];
    if (d_neg) begin
      psum = {{2{prev[31]}}, prev} - {2'b00, delta};
    end else begin
      psum = {{2{prev[31]}}, prev} + {2'b00, delta};
    end
    if (!psum[33] && (psum[32:31] != 2'b00)) begin
      smoothed = oeal_pkg::SMAX;
    end else if (psum[33] && (psum[32:31] != 2'b11)) begin
      smoothed = oeal_pkg::SMIN;
    end else begin
      smoothed = psum[31:0];
    end

    // Slope quotient clamp
    q_lim = s_neg ? oeal_pkg::SMIN : oeal_pkg::SMAX;
    q_sat = (drsp.quot > q_lim) ? q_lim : drsp.quot;

    // Cutoff from the slope estimate magnitude
    se_mag  = slope_est[31] ? (~slope_est + 32'd1) : slope_est;
    extra   = (prod[63:48] != 16'd0) ? oeal_pkg::UMAX : prod[47:16];
    cut_sum = {1'b0, base_cutoff} + {1'b0, extra};

    // Scaled cutoff w = fd * 2pi, high half plus carried low half
    w_sum = prod[52:0] + {18'd0, w_acc};
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_FDMUL: begin
        mul_a = freq;
        mul_b = {3'b000, dt};
      end
      ST_WLMUL: begin
        mul_a = prod[47:16];
        mul_b = oeal_pkg::TWO_PI_Q32;
      end
      ST_WHMUL: begin
        mul_a = {16'd0, fd_hi};
        mul_b = oeal_pkg::TWO_PI_Q32;
      end
      ST_SMUL: begin
        mul_a = pmag;
        mul_b = {18'd0, alpha};
      end
      ST_CMUL: begin
        mul_a = speed_gain;
        mul_b = {3'b000, se_mag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider requests: slope quotient or alpha = w / (w + 1)
  always_comb begin
    dcmd = '0;
    if ((state == ST_SDIV) && ({16'd0, smag[31:16]} < dt)) begin
      dcmd.start    = 1'b1;
      dcmd.steps    = oeal_pkg::SLOPE_STEPS;
      dcmd.rem_init = {33'd0, smag[31:16]};
      dcmd.divisor  = {17'd0, dt};
      dcmd.bits     = {smag[15:0], 16'd0};
    end else if (state == ST_ADIV) begin
      dcmd.start    = 1'b1;
      dcmd.steps    = oeal_pkg::ALPHA_STEPS;
      dcmd.rem_init = w;
      dcmd.divisor  = w + {17'd0, oeal_pkg::ONE_Q};
      dcmd.bits     = '0;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = started ? ST_SDIV : ST_OUT;
        end
      end
      ST_SDIV: begin
        state_next = ({16'd0, smag[31:16]} < dt) ? ST_SWAIT : ST_FDMUL;
      end
      ST_SWAIT: begin
        if (drsp.done) begin
          state_next = ST_FDMUL;
        end
      end
      ST_FDMUL: begin
        state_next = (freq == 32'd0) ? ST_SMUL : ST_WLMUL;
      end
      ST_WLMUL: state_next = ST_WHMUL;
      ST_WHMUL: state_next = ST_WSUM;
      ST_WSUM:  state_next = ST_ADIV;
      ST_ADIV:  state_next = ST_AWAIT;
      ST_AWAIT: begin
        if (drsp.done) begin
          state_next = ST_SMUL;
        end
      end
      ST_SMUL: state_next = ST_SADD;
      ST_SADD: state_next = phase ? ST_OUT : ST_CMUL;
      ST_CMUL: state_next = ST_CADD;
      ST_CADD: state_next = ST_FDMUL;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_cutoff  <= oeal_pkg::ONE_Q;
      speed_gain   <= '0;
      slope_cutoff <= oeal_pkg::ONE_Q;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        oeal_pkg::REG_BASE_CUTOFF:  base_cutoff  <= cfg.data;
        oeal_pkg::REG_SPEED_GAIN:   speed_gain   <= cfg.data;
        oeal_pkg::REG_SLOPE_CUTOFF: slope_cutoff <= cfg.data;
        default: ;
      endcase
    end
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate  <= '0;
      slope_est <= '0;
      started   <= 1'b0;
    end else begin
      if ((state == ST_IDLE) && accept && !started) begin
        started   <= 1'b1;
        estimate  <= data_in.sample;
        slope_est <= '0;
      end
      if (state == ST_SADD) begin
        if (phase) begin
          estimate <= smoothed;
        end else begin
          slope_est <= smoothed;
        end
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x_in <= data_in.sample;
        dt   <= (data_in.time_step == 32'd0) ? oeal_pkg::ONE_Q : data_in.time_step;
        res  <= data_in.sample;
      end
      ST_SDIV: begin
        s_neg  <= sdiff[32];
        phase  <= 1'b0;
        freq   <= slope_cutoff;
        // Quotient of 2^32 or more saturates without a division
        target <= sdiff[32] ? oeal_pkg::SMIN : oeal_pkg::SMAX;
      end
      ST_SWAIT: begin
        target <= s_neg ? (~q_sat + 32'd1) : q_sat;
      end
      ST_FDMUL: begin
        alpha <= {1'b1, 16'd0};
      end
      ST_WLMUL: begin
        fd_hi <= prod[63:48];
      end
      ST_WHMUL: begin
        w_acc <= prod[66:32];
      end
      ST_WSUM: begin
        w <= (w_sum > {4'd0, oeal_pkg::W_LIMIT}) ? oeal_pkg::W_LIMIT : w_sum[48:0];
      end
      ST_AWAIT: begin
        alpha <= {1'b0, drsp.quot[15:0]};
      end
      ST_SMUL: begin
        d_neg <= pdiff[32];
      end
      ST_SADD: begin
        res <= smoothed;
      end
      ST_CADD: begin
        phase <= 1'b1;
        freq  <= cut_sum[32] ? oeal_pkg::UMAX : cut_sum[31:0];
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (data_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      out_data <= res;
    end
  end

  assign data_in.ready     = (state == ST_IDLE);
  assign data_out.valid    = out_valid;
  assign data_out.filtered = out_data;
  assign cfg.ready         = 1'b1;

endmodule

/* bench/one_euro_adaptive_lowpass_core_tb.sv */
`timescale 1ns / 1ps

module one_euro_adaptive_lowpass_core_tb;

  localparam int     CLK_HALF  = 2;
  localparam int     LIMIT     = 1_000_000;
  localparam int     PHASES    = 6;
  localparam int     PER_PHASE = 125;
  localparam int     TAIL      = 100;

  // Not a register: writes here must leave the block unchanged
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Wide constants for the filter arithmetic
  localparam logic [63:0] ONE_U    = 64'h0000_0000_0001_0000;
  localparam logic [63:0] D_MASK   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] W_CAP    = 64'h0001_0000_0000_0000;
  localparam logic [63:0] TWO_PI_W = 64'(oeal_pkg::TWO_PI_Q32);
  localparam longint      S_HI     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      S_LO     = -64'sh0000_0000_8000_0000;

  typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] a;       // sample, or register data
    logic [31:0] b;       // time step
    bit          known;   // expected value typed in below
    logic [31:0] want;
  } plan_row_t;

  typedef struct {
    logic [31:0] filtered;
    int          seq;
  } filtered_exp_t;

  logic clk = 1'b0;
  logic rst;

  oeal_in_if  in_ch ();
  oeal_out_if out_ch ();
  oeal_cfg_if cfg_ch ();

  one_euro_adaptive_lowpass_core dut (
    .clk      (clk),
    .rst      (rst),
    .data_in  (in_ch),
    .data_out (out_ch),
    .cfg      (cfg_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // Mirror of the block: registers and filter state
  logic [63:0] cut_min, gain, cut_slope;
  longint      est, slope_est;
  bit          seen_first;

  filtered_exp_t filtered_q[$];
  plan_row_t     plan[$];
  int            mismatches = 0;
  int            accepted   = 0;
  int            burst_left = 0;
  int            cycles     = 0;

  // ---------------------------------------------------------------------
  // Filter arithmetic
  // ---------------------------------------------------------------------

  // min((a*b) >> sh, lim)
  function automatic logic [63:0] mul_shift_clip(input logic [63:0] a, input logic [63:0] b,
                                                 input int sh, input logic [63:0] lim);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p > {64'd0, lim}) return lim;
    return p[63:0];
  endfunction

  // min(floor(n / d), lim)
  function automatic logic [63:0] div_clip(input logic [127:0] n, input logic [63:0] d,
                                           input logic [63:0] lim);
    logic [127:0] q;
    q = n / {64'd0, d};
    if (q > {64'd0, lim}) return lim;
    return q[63:0];
  endfunction

  function automatic longint clip_s(input longint v);
    if (v > S_HI) return S_HI;
    if (v < S_LO) return S_LO;
    return v;
  endfunction

  // Smoothing factor w/(w+1), w = 2*pi*f*dt; exactly one for a zero cutoff
  function automatic logic [63:0] alpha_q(input logic [63:0] f, input logic [63:0] dt);
    logic [63:0] fd, w;
    if (f == 0) return ONE_U;
    fd = mul_shift_clip(f, dt, oeal_pkg::FRAC_W, W_CAP);
    w  = mul_shift_clip(fd, TWO_PI_W, 32, W_CAP);
    return div_clip({64'd0, w} << oeal_pkg::FRAC_W, w + ONE_U, ONE_U);
  endfunction

  // prev + alpha*(x - prev), magnitude truncated, result saturated
  function automatic longint lowpass(input longint prev, input longint x, input logic [63:0] a);
    longint      diff, delta, r;
    logic [63:0] mag;
    diff  = x - prev;
    mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
    delta = longint'(mul_shift_clip(mag, a, oeal_pkg::FRAC_W, D_MASK));
    r     = (diff < 0) ? prev - delta : prev + delta;
    return clip_s(r);
  endfunction

  // One accepted sample: advance the mirrored state, return the new estimate
  function automatic logic [31:0] predict_filtered(input logic [31:0] s, input logic [31:0] ts);
    longint      x, diff, slope;
    logic [63:0] dt, mag, q, cutoff, extra;
    x  = longint'(signed'(s));
    dt = (ts == 0) ? ONE_U : {32'd0, ts};
    // first sample after reset passes straight through
    if (!seen_first) begin
      seen_first = 1'b1;
      est        = x;
      slope_est  = 0;
      return s;
    end
    diff  = x - est;
    mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
    q     = div_clip({64'd0, mag} << oeal_pkg::FRAC_W, dt,
                     (diff < 0) ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF);
    slope = (diff < 0) ? -longint'(q) : longint'(q);
    slope_est = lowpass(slope_est, slope, alpha_q(cut_slope, dt));
    mag    = (slope_est < 0) ? 64'(-slope_est) : 64'(slope_est);
    extra  = mul_shift_clip(gain, mag, oeal_pkg::FRAC_W, D_MASK);
    cutoff = cut_min + extra;
    if (cutoff > D_MASK) cutoff = D_MASK;
    est = lowpass(est, x, alpha_q(cutoff, dt));
    return 32'(est);
  endfunction

  // ---------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------

  function automatic void plan_item(input logic [31:0] s, input logic [31:0] ts);
    plan_row_t r;
    r = '{kind: ROW_ITEM, idx: 2'd0, a: s, b: ts, known: 1'b0, want: 32'd0};
    plan.push_back(r);
  endfunction

  function automatic void plan_fixed(input logic [31:0] s, input logic [31:0] ts,
                                     input logic [31:0] want);
    plan_row_t r;
    r = '{kind: ROW_ITEM, idx: 2'd0, a: s, b: ts, known: 1'b1, want: want};
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(input logic [1:0] idx, input logic [31:0] val);
    plan_row_t r;
    r = '{kind: ROW_REG, idx: idx, a: val, b: 32'd0, known: 1'b0, want: 32'd0};
    plan.push_back(r);
  endfunction

  // Register value mix: zero, full scale, round one, a few hertz, anything
  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return oeal_pkg::UMAX;
      2:       return oeal_pkg::ONE_Q;
      3:       return $urandom_range(0, 32'h0004_0000);
      4:       return $urandom_range(32'h0000_1000, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want, input int seq);
    $display("mismatch: %s, sample %0d: got %h want %h", what, seq, got, want);
    mismatches++;
  endtask

  // One input transaction, then the sender's burst/gap pacing
  task automatic send_sample(input logic [31:0] s, input logic [31:0] ts,
                             input bit known, input logic [31:0] want);
    logic [31:0]   guess;
    filtered_exp_t e;
    cfg_ch.valid     <= 1'b0;   // close any register write run
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.time_step  <= ts;
    do @(posedge clk); while (!in_ch.ready);
    guess = predict_filtered(s, ts);
    e.filtered = known ? want : guess;
    e.seq      = accepted;
    filtered_q.push_back(e);
    accepted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 100)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // Hold off input and let every outstanding result come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  // Register write transaction; valid is lowered by the next sample send
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      oeal_pkg::REG_BASE_CUTOFF:  cut_min   = {32'd0, val};
      oeal_pkg::REG_SPEED_GAIN:   gain      = {32'd0, val};
      oeal_pkg::REG_SLOPE_CUTOFF: cut_slope = {32'd0, val};
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    filtered_exp_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("result with no transaction waiting", out_ch.filtered, 32'd0, -1);
      end else begin
        e = filtered_q.pop_front();
        if (out_ch.filtered !== e.filtered)
          report_mismatch("filtered", out_ch.filtered, e.filtered, e.seq);
      end
    end
  end

  // Receiver: alternating ready and stall runs, with long stall-free stretches
  initial begin
    int run_left;
    bit hold;
    out_ch.ready <= 1'b0;
    run_left = 0;
    hold     = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        hold = ~hold;
        if (hold)
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                 : $urandom_range(1, 30);
        else
          run_left = $urandom_range(1, 40);
        out_ch.ready <= hold;
      end
      run_left--;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("one_euro_adaptive_lowpass_core_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    logic [31:0] s, ts;
    longint      level;

    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.sample     <= '0;
    in_ch.time_step  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;

    // reset values of the mirrored block
    cut_min    = ONE_U;
    gain       = 64'd0;
    cut_slope  = ONE_U;
    est        = 0;
    slope_est  = 0;
    seen_first = 1'b0;
    level      = 0;

    // first sample passes through, zero step, then saturated slopes
    plan_fixed(oeal_pkg::SMIN, 32'd0, oeal_pkg::SMIN);
    plan_item(oeal_pkg::SMAX, oeal_pkg::ONE_Q);
    plan_item(oeal_pkg::SMIN, 32'd1);
    plan_item(32'd0, oeal_pkg::UMAX);
    // zero cutoff: the estimate jumps to each new sample
    plan_reg(oeal_pkg::REG_BASE_CUTOFF, 32'd0);
    plan_fixed(32'h1234_5678, 32'h0000_8000, 32'h1234_5678);
    plan_fixed(oeal_pkg::SMAX, 32'd0, oeal_pkg::SMAX);
    plan_fixed(oeal_pkg::SMIN, oeal_pkg::UMAX, oeal_pkg::SMIN);
    plan_reg(oeal_pkg::REG_SLOPE_CUTOFF, 32'd0);
    plan_fixed(oeal_pkg::ONE_Q, oeal_pkg::ONE_Q, oeal_pkg::ONE_Q);
    // full-scale registers, plus a write to the unused index
    plan_reg(oeal_pkg::REG_SPEED_GAIN, oeal_pkg::UMAX);
    plan_reg(oeal_pkg::REG_BASE_CUTOFF, oeal_pkg::UMAX);
    plan_reg(oeal_pkg::REG_SLOPE_CUTOFF, oeal_pkg::UMAX);
    plan_reg(REG_UNUSED, 32'hDEAD_BEEF);
    plan_item(oeal_pkg::SMAX, oeal_pkg::UMAX);
    plan_item(oeal_pkg::SMIN, 32'd1);
    plan_item(32'hFFFF_FFFF, 32'd0);
    plan_item(32'h0000_0001, 32'h0000_0100);
    // smallest nonzero settings
    plan_reg(oeal_pkg::REG_BASE_CUTOFF, 32'd1);
    plan_reg(oeal_pkg::REG_SPEED_GAIN, 32'd1);
    plan_reg(oeal_pkg::REG_SLOPE_CUTOFF, 32'd1);
    plan_item(32'h0100_0000, 32'd1);
    plan_item(32'h00FF_0000, oeal_pkg::UMAX);
    plan_item(32'hFFFF_F000, 32'h0000_0400);
    // typical tuning, slow ramp
    plan_reg(oeal_pkg::REG_BASE_CUTOFF, oeal_pkg::ONE_Q);
    plan_reg(oeal_pkg::REG_SPEED_GAIN, 32'h0000_4000);
    plan_reg(oeal_pkg::REG_SLOPE_CUTOFF, oeal_pkg::ONE_Q);
    plan_item(32'h0001_0000, 32'h0000_0444);
    plan_item(32'h0002_0000, 32'd0);
    plan_item(32'h0003_0000, 32'h0000_1000);
    plan_item(32'h0002_8000, 32'h0000_1000);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].a);
      end else begin
        send_sample(plan[i].a, plan[i].b, plan[i].known, plan[i].want);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(oeal_pkg::REG_BASE_CUTOFF, pick_rate());
      write_reg(oeal_pkg::REG_SPEED_GAIN, pick_rate());
      write_reg(oeal_pkg::REG_SLOPE_CUTOFF, pick_rate());
      for (int k = 0; k < PER_PHASE; k++) begin
        // mostly a wandering signal, with jumps and near-rail values
        case ($urandom_range(0, 19))
          0, 1, 2: s = $urandom;
          3, 4: begin
            if ($urandom_range(0, 1)) s = oeal_pkg::SMAX - $urandom_range(0, 32'h0003_0000);
            else                      s = oeal_pkg::SMIN + $urandom_range(0, 32'h0003_0000);
          end
          default: begin
            level = clip_s(level + longint'($urandom_range(0, 32'h0004_0000))
                           - 64'sh0000_0000_0002_0000);
            s = 32'(level);
          end
        endcase
        level = longint'(signed'(s));
        case ($urandom_range(0, 9))
          0:       ts = 32'd0;
          1:       ts = $urandom;
          2:       ts = $urandom_range(1, 32'h0000_0100);
          default: ts = $urandom_range(32'h0000_0100, 32'h0000_4000);
        endcase
        send_sample(s, ts, 1'b0, 32'd0);
      end
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("one_euro_adaptive_lowpass_core_tb: clean");
    end else begin
      $display("one_euro_adaptive_lowpass_core_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/oeal_pkg.sv
sv/oeal_if.sv
sv/oeal_mul.sv
sv/oeal_div.sv
sv/one_euro_adaptive_lowpass_core.sv
bench/one_euro_adaptive_lowpass_core_tb.sv
